// ===== hw/rtl/hav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_pkg
// Shared constants and types of the haversine distance core: Q30 angle
// constants, series length and the lane payload types.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int unsigned SeriesTerms = 12;
  localparam int unsigned AngW        = 31;
  localparam int unsigned SumW        = 34;

  localparam logic [30:0] Q30One    = 31'd1073741824;
  localparam logic [31:0] PiQ30     = 32'd3373259426;
  localparam logic [32:0] TwoPiQ30  = 33'd6746518852;
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;
  localparam logic [21:0] SepMax    = 22'd3294199;

  // reduced angle in Q30, always within 0 .. pi/2
  typedef logic [AngW-1:0] ang_t;
  // running Taylor sum
  typedef logic signed [SumW-1:0] sum_t;

endpackage

// ===== hw/rtl/hav_series.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_series
// Pipelined 12-term Taylor series for cos or sin of a reduced Q30 angle.
// Each term takes three stages: term * r^2, reciprocal multiply, correction.
// ----------------------------------------------------------------------------
module hav_series #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned SideW = 1,
  parameter bit          IsSin = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  hav_pkg::ang_t      r_i [Lanes],
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output hav_pkg::sum_t      sum_o [Lanes],
  output logic [SideW-1:0]   side_o
);
  import hav_pkg::*;

  localparam int unsigned NStage = 1 + 3 * (SeriesTerms - 1);

  logic             vld_q  [NStage];
  logic [SideW-1:0] side_q [NStage];
  logic [31:0]      r2_d   [NStage][Lanes];
  logic [31:0]      r2_q   [NStage][Lanes];
  logic [31:0]      x_d    [NStage][Lanes];
  logic [31:0]      x_q    [NStage][Lanes];
  logic [31:0]      y_d    [NStage][Lanes];
  logic [31:0]      y_q    [NStage][Lanes];
  sum_t             sum_d  [NStage][Lanes];
  sum_t             sum_q  [NStage][Lanes];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane0
    logic [61:0] sq;
    assign sq          = 62'(r_i[l]) * 62'(r_i[l]);
    assign r2_d[0][l]  = sq[61:30];
    assign x_d[0][l]   = IsSin ? {1'b0, r_i[l]} : 32'(Q30One);
    assign y_d[0][l]   = '0;
    assign sum_d[0][l] = IsSin ? sum_t'({3'b000, r_i[l]}) : sum_t'({3'b000, Q30One});
  end

  for (genvar s = 1; s < NStage; s++) begin : g_stage
    localparam int unsigned Term  = (s + 2) / 3;
    localparam int unsigned Phase = (s - 1) % 3;
    localparam int unsigned Div   = IsSin ? (2 * Term) * (2 * Term + 1)
                                          : (2 * Term - 1) * (2 * Term);
    localparam int unsigned Shift = 31 + $clog2(Div + 1) - 1;
    localparam logic [63:0] RecipFull = (64'd1 << Shift) / Div;
    localparam logic [31:0] Recip = RecipFull[31:0];

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      assign r2_d[s][l] = r2_q[s-1][l];
      if (Phase == 0) begin : g_mul
        logic [63:0] prod;
        assign prod        = 64'(x_q[s-1][l]) * 64'(r2_q[s-1][l]);
        assign x_d[s][l]   = prod[61:30];
        assign y_d[s][l]   = y_q[s-1][l];
        assign sum_d[s][l] = sum_q[s-1][l];
      end else if (Phase == 1) begin : g_recip
        logic [63:0] prod;
        logic [63:0] shifted;
        assign prod        = 64'(x_q[s-1][l]) * 64'(Recip);
        assign shifted     = prod >> Shift;
        assign x_d[s][l]   = x_q[s-1][l];
        assign y_d[s][l]   = shifted[31:0];
        assign sum_d[s][l] = sum_q[s-1][l];
      end else begin : g_fix
        logic [63:0] back;
        logic [63:0] rem;
        logic [31:0] quot;
        // estimate is low by at most one: bump it when the remainder reaches Div
        assign back      = 64'(y_q[s-1][l]) * 64'(Div);
        assign rem       = 64'(x_q[s-1][l]) - back;
        assign quot      = y_q[s-1][l] + 32'(rem >= 64'(Div));
        assign x_d[s][l] = quot;
        assign y_d[s][l] = y_q[s-1][l];
        if ((Term % 2) == 1) begin : g_sub
          assign sum_d[s][l] = sum_q[s-1][l] - sum_t'({2'b00, quot});
        end else begin : g_add
          assign sum_d[s][l] = sum_q[s-1][l] + sum_t'({2'b00, quot});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NStage; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < NStage; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < NStage; s++) side_q[s] <= side_q[s-1];
      for (int s = 0; s < NStage; s++) begin
        for (int l = 0; l < Lanes; l++) begin
          r2_q[s][l]  <= r2_d[s][l];
          x_q[s][l]   <= x_d[s][l];
          y_q[s][l]   <= y_d[s][l];
          sum_q[s][l] <= sum_d[s][l];
        end
      end
    end
  end

  assign valid_o = vld_q[NStage-1];
  assign side_o  = side_q[NStage-1];
  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign sum_o[l] = sum_q[NStage-1][l];
  end

endmodule

// ===== hw/rtl/haversine_angular_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_angular_distance_core
// Great-circle separation of two sky positions by the haversine formula.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries one request: two (ra, dec) pairs in Q3.20
//   radians. Master channel m_axis_* returns one separation per request in
//   Q2.20 radians (0 .. pi), in request order.
//   The pipeline has 3 reduction stages, a 34-stage cosine series for
//   four angles, 4 combine stages, a 32-stage square root, then 22 arcsine
//   search steps of 36 stages each (one sine series per step).
//   One request per cycle unless stalled; every stage is a plain register.
//   When m_axis_tready is low while a result waits, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module haversine_angular_distance_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ra_first[23:0], dec_first[47:24], ra_second[71:48], dec_second[95:72]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // separation[21:0], zero fill [23:22]
  output logic [23:0] m_axis_tdata
);
  import hav_pkg::*;

  localparam int unsigned CosLanes    = 4;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned SearchIters = 22;
  localparam logic [34:0] TwoTwoPi    = 35'(TwoPiQ30) << 1;

  typedef struct packed {
    logic [21:0] lo;
    logic [21:0] hi;
    logic [21:0] mid;
    logic [30:0] root;
  } sch_t;

  function automatic logic [30:0] abs32(logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? n[30:0] : v[30:0];
  endfunction

  logic en;

  // ---- stage 1: differences, magnitudes in Q30 ----
  logic [23:0]        ra1, dec1, ra2, dec2;
  logic signed [24:0] ang [CosLanes];
  logic [24:0]        mag [CosLanes];
  logic               v1_q;
  logic [34:0]        ax1_q [CosLanes];

  assign ra1  = s_axis_tdata[23:0];
  assign dec1 = s_axis_tdata[47:24];
  assign ra2  = s_axis_tdata[71:48];
  assign dec2 = s_axis_tdata[95:72];

  // lanes: dec difference, ra difference, dec first, dec second
  assign ang[0] = {dec2[23], dec2} - {dec1[23], dec1};
  assign ang[1] = {ra2[23], ra2} - {ra1[23], ra1};
  assign ang[2] = {dec1[23], dec1};
  assign ang[3] = {dec2[23], dec2};

  for (genvar l = 0; l < CosLanes; l++) begin : g_mag
    assign mag[l] = ang[l][24] ? 25'(-ang[l]) : ang[l];
  end

  // ---- stage 2: reduce modulo 2*pi ----
  logic        v2_q;
  logic [32:0] red_d [CosLanes];
  logic [32:0] red_q [CosLanes];

  for (genvar l = 0; l < CosLanes; l++) begin : g_red
    assign red_d[l] = (ax1_q[l] >= TwoTwoPi) ? 33'(ax1_q[l] - TwoTwoPi) :
                      (ax1_q[l] >= 35'(TwoPiQ30)) ? 33'(ax1_q[l] - 35'(TwoPiQ30)) :
                      ax1_q[l][32:0];
  end

  // ---- stage 3: fold into 0 .. pi/2 ----
  logic         v3_q;
  ang_t         r3_d   [CosLanes];
  ang_t         r3_q   [CosLanes];
  logic [CosLanes-1:0] neg3_d, neg3_q;

  for (genvar l = 0; l < CosLanes; l++) begin : g_fold
    logic [32:0] f;
    logic [32:0] g;
    assign f         = (red_q[l] > 33'(PiQ30)) ? TwoPiQ30 - red_q[l] : red_q[l];
    assign neg3_d[l] = f > 33'(HalfPiQ30);
    assign g         = neg3_d[l] ? 33'(PiQ30) - f : f;
    assign r3_d[l]   = g[30:0];
  end

  // ---- cosine series ----
  logic                cos_vld;
  sum_t                cos_sum [CosLanes];
  logic [CosLanes-1:0] cos_neg;

  hav_series #(
    .Lanes (CosLanes),
    .SideW (CosLanes),
    .IsSin (1'b0)
  ) u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .r_i     (r3_q),
    .side_i  (neg3_q),
    .valid_o (cos_vld),
    .sum_o   (cos_sum),
    .side_o  (cos_neg)
  );

  // ---- stage 4: clamp and restore sign ----
  logic               v4_q;
  logic signed [31:0] c4_d [CosLanes];
  logic signed [31:0] c4_q [CosLanes];

  for (genvar l = 0; l < CosLanes; l++) begin : g_clamp
    logic [30:0] cm;
    assign cm = (cos_sum[l] > sum_t'({3'b000, Q30One})) ? Q30One :
                cos_sum[l][SumW-1] ? '0 : cos_sum[l][30:0];
    assign c4_d[l] = cos_neg[l] ? -{1'b0, cm} : {1'b0, cm};
  end

  // ---- stage 5: half-versines and cos1*cos2 ----
  logic               v5_q;
  logic [30:0]        t1_d, t1_q, hra_d, hra_q;
  logic signed [31:0] p12_d, p12_q;
  logic signed [32:0] dcd, dca;
  logic [61:0]        m12;
  logic [31:0]        p12m;

  assign dcd   = 33'(Q30One) - {c4_q[0][31], c4_q[0]};
  assign dca   = 33'(Q30One) - {c4_q[1][31], c4_q[1]};
  assign t1_d  = dcd[31:1];
  assign hra_d = dca[31:1];
  assign m12   = 62'(abs32(c4_q[2])) * 62'(abs32(c4_q[3]));
  assign p12m  = m12[61:30];
  assign p12_d = (c4_q[2][31] ^ c4_q[3][31]) ? -p12m : p12m;

  // ---- stage 6: times the ra half-versine ----
  logic               v6_q;
  logic [30:0]        t1b_q;
  logic signed [31:0] t2_d, t2_q;
  logic [61:0]        m2;
  logic [31:0]        p2m;

  assign m2   = 62'(abs32(p12_q)) * 62'(hra_q);
  assign p2m  = m2[61:30];
  assign t2_d = p12_q[31] ? -p2m : p2m;

  // ---- stage 7: sum and saturate ----
  logic               v7_q;
  logic [30:0]        h7_d, h7_q;
  logic signed [32:0] hs;

  // a negative sum saturates to zero before the upper bound is checked
  assign hs   = {2'b00, t1b_q} + {t2_q[31], t2_q};
  assign h7_d = hs[32] ? '0 : (hs[31:0] > 32'(Q30One)) ? Q30One : hs[30:0];

  // ---- square root, one result bit per stage ----
  logic        sq_vld_q [SqrtSteps];
  logic [63:0] sq_v_d   [SqrtSteps];
  logic [63:0] sq_v_q   [SqrtSteps];
  logic [63:0] sq_r_d   [SqrtSteps];
  logic [63:0] sq_r_q   [SqrtSteps];

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
    logic [63:0] vin, rin, t;
    if (i == 0) begin : g_first
      assign vin = {3'b000, h7_q, 30'd0};
      assign rin = '0;
    end else begin : g_next
      assign vin = sq_v_q[i-1];
      assign rin = sq_r_q[i-1];
    end
    assign t         = rin + Bit;
    assign sq_v_d[i] = (vin >= t) ? vin - t : vin;
    assign sq_r_d[i] = (vin >= t) ? (rin >> 1) + Bit : rin >> 1;
  end

  // ---- arcsine by binary search over sine series ----
  logic  mvld_q [SearchIters];
  sch_t  mid_d  [SearchIters];
  sch_t  mid_q  [SearchIters];
  ang_t  sr     [SearchIters][1];
  logic  svld   [SearchIters];
  sum_t  ssum   [SearchIters][1];
  logic [$bits(sch_t)-1:0] sside [SearchIters];
  logic  uvld_q [SearchIters];
  sch_t  upd_d  [SearchIters];
  sch_t  upd_q  [SearchIters];

  for (genvar it = 0; it < SearchIters; it++) begin : g_search
    sch_t        src;
    logic [22:0] span;
    sch_t        so;
    logic        le;

    if (it == 0) begin : g_first
      assign src = '{lo: '0, hi: SepMax, mid: '0, root: sq_r_q[SqrtSteps-1][30:0]};
    end else begin : g_next
      assign src = upd_q[it-1];
    end

    assign span = 23'(src.hi) - 23'(src.lo) + 23'd1;
    always_comb begin
      mid_d[it]     = src;
      mid_d[it].mid = src.lo + span[22:1];
    end

    assign sr[it][0] = {mid_q[it].mid, 9'd0};

    hav_series #(
      .Lanes (1),
      .SideW ($bits(sch_t)),
      .IsSin (1'b1)
    ) u_sin (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (mvld_q[it]),
      .r_i     (sr[it]),
      .side_i  (mid_q[it]),
      .valid_o (svld[it]),
      .sum_o   (ssum[it]),
      .side_o  (sside[it])
    );

    assign so = sch_t'(sside[it]);
    assign le = ssum[it][0] <= sum_t'({3'b000, so.root});

    // narrow only while the interval is still open
    always_comb begin
      upd_d[it] = so;
      if (so.lo < so.hi) begin
        if (le) upd_d[it].lo = so.mid;
        else    upd_d[it].hi = so.mid - 22'd1;
      end
    end
  end

  // ---- handshake ----
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = uvld_q[SearchIters-1];
  assign m_axis_tdata  = {2'b00, upd_q[SearchIters-1].lo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      for (int i = 0; i < SqrtSteps; i++) sq_vld_q[i] <= 1'b0;
      for (int i = 0; i < SearchIters; i++) begin
        mvld_q[i] <= 1'b0;
        uvld_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= cos_vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      sq_vld_q[0] <= v7_q;
      for (int i = 1; i < SqrtSteps; i++) sq_vld_q[i] <= sq_vld_q[i-1];
      mvld_q[0] <= sq_vld_q[SqrtSteps-1];
      for (int i = 1; i < SearchIters; i++) mvld_q[i] <= uvld_q[i-1];
      for (int i = 0; i < SearchIters; i++) uvld_q[i] <= svld[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < CosLanes; l++) begin
        ax1_q[l] <= {mag[l], 10'd0};
        red_q[l] <= red_d[l];
        r3_q[l]  <= r3_d[l];
        c4_q[l]  <= c4_d[l];
      end
      neg3_q <= neg3_d;
      t1_q   <= t1_d;
      hra_q  <= hra_d;
      p12_q  <= p12_d;
      t1b_q  <= t1_q;
      t2_q   <= t2_d;
      h7_q   <= h7_d;
      for (int i = 0; i < SqrtSteps; i++) begin
        sq_v_q[i] <= sq_v_d[i];
        sq_r_q[i] <= sq_r_d[i];
      end
      for (int i = 0; i < SearchIters; i++) begin
        mid_q[i] <= mid_d[i];
        upd_q[i] <= upd_d[i];
      end
    end
  end

  // ---- assertions ----
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted request did not enter stage 1");

  a_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (r3_q[0] <= HalfPiQ30) && (r3_q[1] <= HalfPiQ30) &&
             (r3_q[2] <= HalfPiQ30) && (r3_q[3] <= HalfPiQ30))
    else $error("folded angle beyond pi/2");

  a_hav: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q |-> h7_q <= Q30One)
    else $error("haversine not saturated");

  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[SqrtSteps-1] |-> sq_r_q[SqrtSteps-1] <= 64'(Q30One))
    else $error("square root out of range");

  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (upd_q[SearchIters-1].lo <= upd_q[SearchIters-1].hi) &&
                      (upd_q[SearchIters-1].lo <= SepMax))
    else $error("search interval broken");

endmodule
